/* sv/epls_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and helpers of the exclusion process lattice block
package epls_pkg;

    localparam int SITES_DEF = 128;
    localparam int CNT_W     = 32;
    localparam int PROB_W    = 16;
    localparam int SITE_W    = 8;
    localparam int OP_W      = 2;
    localparam int REG_IDX_W = 3;

    // operation codes; the unused code behaves as a read
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_SWEEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_LEFT_ENTRY    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_EXIT     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_ENTRY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_EXIT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD_HOP   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BACKWARD_HOP  = 3'd5;

    typedef logic [PROB_W-1:0] t_prob;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SITE_W-1:0] site;
        t_prob             roll_first;
        t_prob             roll_second;
        t_prob             roll_forward;
        t_prob             roll_backward;
        logic              measuring;
    } t_item;

    typedef struct packed {
        logic   site_occupied;
        t_count forward_current;
        t_count backward_current;
        t_count occupancy_count;
    } t_result;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        t_prob                value;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_TEST,
        ST_STORE,
        ST_SWEEP,
        ST_FETCH,
        ST_DONE
    } t_state;

    function automatic t_count sat_inc(input t_count v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* sv/epls_chan_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying one payload beat
interface epls_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/epls_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module epls_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* sv/exclusion_process_lattice_step_top.sv */
`timescale 1ns / 1ps
// exclusion process lattice: occupancy bits, site counters and middle-site currents
// per item: an update reads the three neighbouring bits, runs four roll tests on the one
//   comparator, writes the bits back, fetches and loads the result; a counting sweep walks
//   every site, anything else only fetches; next item taken from the cycle the result rises
// reset: synchronous, active low; afterwards a clearing pass over every site zeroes both
//   rams while the item channel holds ready low (configuration beats are taken throughout)
module exclusion_process_lattice_step_top #(
    parameter int SITES = epls_pkg::SITES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    epls_chan_if.sink   i_item,
    epls_chan_if.source o_result,
    epls_chan_if.sink   i_cfg
);
    import epls_pkg::*;

    localparam int AW       = $clog2(SITES);
    localparam int PW       = $clog2(SITES + 1);
    localparam int MID_IDX  = SITES / 2 - 1;
    localparam int LAST_IDX = SITES - 1;

    t_state r_state, n_state;

    // configuration registers
    t_prob r_left_entry, r_left_exit, r_right_entry, r_right_exit;
    t_prob r_fwd_prob, r_bwd_prob;

    // latched item and working copies of the three neighbouring bits
    t_item          r_item;
    logic [AW-1:0]  r_idx;
    logic           r_site_ok;
    logic [1:0]     r_step;
    logic [PW-1:0]  r_ptr;
    logic           r_left, r_mid, r_right;
    logic           r_wb_en;
    logic [AW-1:0]  r_wb_addr;
    t_count         r_fwd, r_bwd;

    // output register, frees the item side from the result side
    logic    r_out_valid;
    t_result r_out;

    // ram ports
    logic          occ_we, occ_wdata, occ_rdata;
    logic [AW-1:0] occ_waddr, occ_raddr;
    logic          cnt_we;
    logic [AW-1:0] cnt_waddr, cnt_raddr;
    t_count        cnt_wdata, cnt_rdata;

    // neighbour addressing, clamped at the lattice ends
    logic          is_first, is_last, is_mid;
    logic [AW-1:0] prev_idx, next_idx;

    // shared roll comparator
    t_prob roll_sel, prob_sel;
    logic  hit;
    logic  n_left, n_mid, n_right, fwd_move, bwd_move;

    logic item_beat, cfg_beat, out_free;
    logic in_site_ok;

    assign item_beat = i_item.valid && i_item.ready;
    assign cfg_beat  = i_cfg.valid && i_cfg.ready;
    assign out_free  = !r_out_valid || o_result.ready;

    assign in_site_ok = (i_item.data.site != '0)
                     && (32'(i_item.data.site) <= 32'(SITES));

    assign is_first = (r_idx == '0);
    assign is_last  = (r_idx == AW'(LAST_IDX));
    assign is_mid   = (r_idx == AW'(MID_IDX));
    assign prev_idx = is_first ? r_idx : r_idx - AW'(1);
    assign next_idx = is_last  ? r_idx : r_idx + AW'(1);

    assign i_item.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_ptr == PW'(SITES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (item_beat) begin
                    case (i_item.data.operation)
                        OP_UPDATE: n_state = in_site_ok ? ST_LOAD : ST_FETCH;
                        OP_SWEEP:  n_state = i_item.data.measuring ? ST_SWEEP : ST_FETCH;
                        default:   n_state = ST_FETCH;
                    endcase
                end
            end
            ST_LOAD: begin
                if (r_step == 2'd3) n_state = ST_TEST;
            end
            ST_TEST: begin
                if (r_step == 2'd3) n_state = ST_STORE;
            end
            ST_STORE: begin
                if (r_step == 2'd2) n_state = ST_FETCH;
            end
            ST_SWEEP: begin
                if (r_ptr == PW'(SITES)) n_state = ST_FETCH;
            end
            ST_FETCH: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ram control per state
    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = r_idx;
        occ_wdata = r_mid;
        occ_raddr = r_idx;
        cnt_we    = 1'b0;
        cnt_waddr = r_wb_addr;
        cnt_wdata = sat_inc(cnt_rdata);
        cnt_raddr = r_idx;
        case (r_state)
            ST_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = r_ptr[AW-1:0];
                occ_wdata = 1'b0;
                cnt_we    = 1'b1;
                cnt_waddr = r_ptr[AW-1:0];
                cnt_wdata = '0;
            end
            ST_LOAD: begin
                case (r_step)
                    2'd0:    occ_raddr = prev_idx;
                    2'd2:    occ_raddr = next_idx;
                    default: occ_raddr = r_idx;
                endcase
            end
            ST_STORE: begin
                case (r_step)
                    2'd0: begin
                        occ_we    = !is_first;
                        occ_waddr = prev_idx;
                        occ_wdata = r_left;
                    end
                    2'd1: begin
                        occ_we    = 1'b1;
                        occ_waddr = r_idx;
                        occ_wdata = r_mid;
                    end
                    default: begin
                        occ_we    = !is_last;
                        occ_waddr = next_idx;
                        occ_wdata = r_right;
                    end
                endcase
            end
            ST_SWEEP: begin
                // read site k while writing back site k-1
                occ_raddr = r_ptr[AW-1:0];
                cnt_raddr = r_ptr[AW-1:0];
                cnt_we    = r_wb_en && occ_rdata;
            end
            default: ;
        endcase
    end

    // one comparator, stepped through the four roll tests
    always_comb begin
        case (r_step)
            2'd0: begin
                roll_sel = r_item.roll_first;
                prob_sel = is_first ? r_left_entry : r_right_exit;
            end
            2'd1: begin
                roll_sel = r_item.roll_second;
                prob_sel = is_first ? r_left_exit : r_right_entry;
            end
            2'd2: begin
                roll_sel = r_item.roll_forward;
                prob_sel = r_fwd_prob;
            end
            default: begin
                roll_sel = r_item.roll_backward;
                prob_sel = r_bwd_prob;
            end
        endcase
        hit = (roll_sel < prob_sel);

        n_left   = r_left;
        n_mid    = r_mid;
        n_right  = r_right;
        fwd_move = 1'b0;
        bwd_move = 1'b0;
        case (r_step)
            2'd0: begin
                // left injection, or right extraction
                if (is_first && !r_mid && hit) n_mid = 1'b1;
                if (is_last && r_mid && hit)   n_mid = 1'b0;
            end
            2'd1: begin
                // left removal, or right injection; may undo the first test
                if (is_first && r_mid && hit)  n_mid = 1'b0;
                if (is_last && !r_mid && hit)  n_mid = 1'b1;
            end
            2'd2: begin
                fwd_move = !is_last && r_mid && !r_right && hit;
                if (fwd_move) begin
                    n_right = 1'b1;
                    n_mid   = 1'b0;
                end
            end
            default: begin
                bwd_move = !is_first && r_mid && !r_left && hit;
                if (bwd_move) begin
                    n_left = 1'b1;
                    n_mid  = 1'b0;
                end
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_entry  <= '0;
            r_left_exit   <= '0;
            r_right_entry <= '0;
            r_right_exit  <= '0;
            r_fwd_prob    <= '0;
            r_bwd_prob    <= '0;
        end else if (cfg_beat) begin
            case (i_cfg.data.index)
                REG_LEFT_ENTRY:   r_left_entry  <= i_cfg.data.value;
                REG_LEFT_EXIT:    r_left_exit   <= i_cfg.data.value;
                REG_RIGHT_ENTRY:  r_right_entry <= i_cfg.data.value;
                REG_RIGHT_EXIT:   r_right_exit  <= i_cfg.data.value;
                REG_FORWARD_HOP:  r_fwd_prob    <= i_cfg.data.value;
                REG_BACKWARD_HOP: r_bwd_prob    <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // sequencer control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_step      <= '0;
            r_wb_en     <= 1'b0;
            r_fwd       <= '0;
            r_bwd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? 2'd0 : r_step + 2'd1;

            case (r_state)
                ST_CLEAR: r_ptr <= r_ptr + PW'(1);
                ST_IDLE: begin
                    r_ptr   <= '0;
                    r_wb_en <= 1'b0;
                end
                ST_SWEEP: begin
                    r_wb_en <= (r_ptr != PW'(SITES));
                    if (r_ptr != PW'(SITES)) r_ptr <= r_ptr + PW'(1);
                end
                ST_TEST: begin
                    if (fwd_move && is_mid && r_item.measuring) r_fwd <= sat_inc(r_fwd);
                    if (bwd_move && is_mid && r_item.measuring) r_bwd <= sat_inc(r_bwd);
                end
                default: ;
            endcase

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (item_beat) begin
            r_item    <= i_item.data;
            r_site_ok <= in_site_ok;
            r_idx     <= in_site_ok ? AW'(32'(i_item.data.site) - 32'd1) : '0;
        end
        r_wb_addr <= r_ptr[AW-1:0];

        case (r_state)
            ST_LOAD: begin
                // read data is registered, so each bit is taken in the step after its address
                case (r_step)
                    2'd1:    r_left  <= occ_rdata;
                    2'd2:    r_mid   <= occ_rdata;
                    2'd3:    r_right <= occ_rdata;
                    default: ;
                endcase
            end
            ST_TEST: begin
                r_left  <= n_left;
                r_mid   <= n_mid;
                r_right <= n_right;
            end
            default: ;
        endcase

        if (r_state == ST_DONE && out_free) begin
            r_out.site_occupied    <= r_site_ok && occ_rdata;
            r_out.forward_current  <= r_fwd;
            r_out.backward_current <= r_bwd;
            r_out.occupancy_count  <= r_site_ok ? cnt_rdata : '0;
        end
    end

    epls_ram #(
        .WIDTH (1),
        .DEPTH (SITES)
    ) u_occ_ram (
        .i_clk     (i_clk),
        .i_wr_en   (occ_we),
        .i_wr_addr (occ_waddr),
        .i_wr_data (occ_wdata),
        .i_rd_addr (occ_raddr),
        .o_rd_data (occ_rdata)
    );

    epls_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SITES)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (cnt_waddr),
        .i_wr_data (cnt_wdata),
        .i_rd_addr (cnt_raddr),
        .o_rd_data (cnt_rdata)
    );
endmodule

/* sv/epls_checker.sv */
`timescale 1ns / 1ps
// port-level checks of the lattice block, bound to its top level
module epls_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input epls_pkg::t_result i_out_data
);
    // reset starts the clearing pass, so no item beat right after it
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("item channel ready directly after reset");

    // one item at a time: an item beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item channel ready in the cycle after an item beat");

    // a result only appears at the end of busy work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised while the block was idle");

    // a stalled result stays put
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed or dropped");
endmodule

bind exclusion_process_lattice_step_top epls_checker u_epls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

/* tb/tb_exclusion_process_lattice_step_top.sv */
`timescale 1ns / 1ps
// self-checking bench for the exclusion process lattice: predicts every result beat and compares
module tb_exclusion_process_lattice_step_top;
    import epls_pkg::*;

    localparam int SITES      = SITES_DEF;
    localparam int MID_SITE   = SITES / 2;
    localparam int NUM_REGS   = 6;
    localparam int RAND_ITEMS = 1400;
    // idle cycles tolerated with no beat on any channel: clearing pass, a full sweep,
    // the longest sender gap and the longest receiver stall, taken several times over
    localparam int WATCHDOG_LIMIT = 8 * (SITES + SITES + 4 + 60 + 60);
    // settle time at the end, longer than the slowest item (a sweep)
    localparam int DRAIN_CYCLES = 2 * SITES + 20;
    localparam int REPORT_MAX   = 10;

    // the spare operation code behaves as a read
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    // indexes past the last register, writes there are dropped
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    localparam t_prob PROB_MAX = 16'hFFFF;
    localparam t_prob PROB_MIN = 16'h0000;

    typedef enum logic {
        BEAT_ITEM,
        BEAT_CFG
    } t_beat_kind;

    typedef struct {
        t_beat_kind kind;
        t_item      item;
        t_cfg_wr    cfg;
    } t_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    epls_chan_if #(.T(t_item))   item_ch ();
    epls_chan_if #(.T(t_result)) res_ch ();
    epls_chan_if #(.T(t_cfg_wr)) cfg_ch ();

    exclusion_process_lattice_step_top #(
        .SITES(SITES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: its own lattice, tallies and probability registers
    // ------------------------------------------------------------------
    logic   lattice_occ [SITES];
    t_count site_tally  [SITES];
    t_count fwd_tally;
    t_count bwd_tally;
    t_prob  prob_reg    [NUM_REGS];

    t_beat   pending_beats[$];
    t_result lattice_results_due[$];

    // handshake bookkeeping, the driver counts what it puts up, the monitor what is taken
    int items_sent  = 0;
    int items_taken = 0;
    int cfgs_sent   = 0;
    int cfgs_taken  = 0;

    int err_count   = 0;
    int idle_cycles = 0;

    // driver private pacing state
    int unsigned item_gap  = 0;
    int unsigned rdy_left  = 0;
    bit          quiet_run = 1'b0;

    function automatic t_count bump_tally(input t_count v);
        if (v == {CNT_W{1'b1}})
            return v;
        return v + 1;
    endfunction

    // one attempt, sweep or read against the predictor lattice; returns the result beat
    function automatic t_result step_lattice(input t_item it);
        int unsigned s;
        int          idx;
        logic        in_range;
        t_result     r;
        s        = it.site;
        in_range = (s >= 1) && (s <= SITES);
        idx      = int'(s) - 1;
        if (it.operation == OP_UPDATE) begin
            if (in_range) begin
                // left boundary: injection first, then removal of whatever sits there
                if (s == 1) begin
                    if (!lattice_occ[idx] && it.roll_first < prob_reg[REG_LEFT_ENTRY])
                        lattice_occ[idx] = 1'b1;
                    if (lattice_occ[idx] && it.roll_second < prob_reg[REG_LEFT_EXIT])
                        lattice_occ[idx] = 1'b0;
                end
                // right boundary: extraction first, then injection
                if (s == SITES) begin
                    if (lattice_occ[idx] && it.roll_first < prob_reg[REG_RIGHT_EXIT])
                        lattice_occ[idx] = 1'b0;
                    if (!lattice_occ[idx] && it.roll_second < prob_reg[REG_RIGHT_ENTRY])
                        lattice_occ[idx] = 1'b1;
                end
                // forward hop, never off the last site
                if (s < SITES && lattice_occ[idx] && !lattice_occ[idx + 1] &&
                    it.roll_forward < prob_reg[REG_FORWARD_HOP]) begin
                    lattice_occ[idx + 1] = 1'b1;
                    lattice_occ[idx]     = 1'b0;
                    if (s == MID_SITE && it.measuring)
                        fwd_tally = bump_tally(fwd_tally);
                end
                // backward hop, never off the first site
                if (s >= 2 && lattice_occ[idx] && !lattice_occ[idx - 1] &&
                    it.roll_backward < prob_reg[REG_BACKWARD_HOP]) begin
                    lattice_occ[idx - 1] = 1'b1;
                    lattice_occ[idx]     = 1'b0;
                    if (s == MID_SITE && it.measuring)
                        bwd_tally = bump_tally(bwd_tally);
                end
            end
        end else if (it.operation == OP_SWEEP) begin
            if (it.measuring) begin
                for (int k = 0; k < SITES; k++)
                    if (lattice_occ[k])
                        site_tally[k] = bump_tally(site_tally[k]);
            end
        end
        r.site_occupied    = in_range ? lattice_occ[idx] : 1'b0;
        r.forward_current  = fwd_tally;
        r.backward_current = bwd_tally;
        r.occupancy_count  = in_range ? site_tally[idx] : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // pacing: mostly short gaps, a few long ones, and stretches with none
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // rolls: full range with the two ends drawn now and then
    function automatic t_prob draw_roll();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return PROB_MIN;
        if (r < 16)
            return PROB_MAX;
        return t_prob'($urandom_range(0, 65535));
    endfunction

    // probabilities lean high so that particles actually travel
    function automatic t_prob draw_prob();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return PROB_MIN;
        if (r < 30)
            return PROB_MAX;
        if (r < 65)
            return t_prob'($urandom_range(16'h8000, 16'hFFFF));
        return t_prob'($urandom_range(0, 65535));
    endfunction

    // sites: some out of range, the boundaries, the middle, and the rest anywhere
    function automatic logic [SITE_W-1:0] draw_site();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return ($urandom_range(0, 2) == 0) ? SITE_W'(0)
                                                : SITE_W'($urandom_range(SITES + 1, 255));
        if (r < 25)
            return ($urandom_range(0, 1) != 0) ? SITE_W'(1) : SITE_W'(SITES);
        if (r < 40)
            return SITE_W'($urandom_range(MID_SITE - 2, MID_SITE + 2));
        return SITE_W'($urandom_range(1, SITES));
    endfunction

    task automatic queue_item(input logic [OP_W-1:0] op, input logic [SITE_W-1:0] site,
                              input logic meas, input t_prob rf, input t_prob rs,
                              input t_prob rfw, input t_prob rbw);
        t_beat b;
        b.kind               = BEAT_ITEM;
        b.item.operation     = op;
        b.item.site          = site;
        b.item.roll_first    = rf;
        b.item.roll_second   = rs;
        b.item.roll_forward  = rfw;
        b.item.roll_backward = rbw;
        b.item.measuring     = meas;
        b.cfg                = '0;
        pending_beats.push_back(b);
    endtask

    task automatic queue_rand_item(input logic [OP_W-1:0] op, input logic [SITE_W-1:0] site,
                                   input logic meas);
        queue_item(op, site, meas, draw_roll(), draw_roll(), draw_roll(), draw_roll());
    endtask

    task automatic queue_cfg(input logic [REG_IDX_W-1:0] idx, input t_prob v);
        t_beat b;
        b.kind      = BEAT_CFG;
        b.item      = '0;
        b.cfg.index = idx;
        b.cfg.value = v;
        pending_beats.push_back(b);
    endtask

    // a full register set per phase, in rotated order, sometimes with a dropped write
    task automatic queue_phase_config(input int phase);
        int                   rot;
        logic [REG_IDX_W-1:0] idx;
        t_prob                v;
        rot = $urandom_range(0, NUM_REGS - 1);
        if ($urandom_range(0, 99) < 30)
            queue_cfg(($urandom_range(0, 1) != 0) ? REG_UNUSED_A : REG_UNUSED_B,
                      t_prob'($urandom));
        for (int j = 0; j < NUM_REGS; j++) begin
            idx = REG_IDX_W'((j + rot) % NUM_REGS);
            case (phase)
                0: begin
                    v = PROB_MAX;
                end
                1: begin
                    v = ($urandom_range(0, 1) != 0) ? PROB_MAX : PROB_MIN;
                end
                default: begin
                    v = draw_prob();
                end
            endcase
            queue_cfg(idx, v);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: puts beats up at the falling edge, one assignment per signal
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_blk
        logic  nxt_item_vld;
        logic  nxt_cfg_vld;
        logic  nxt_rdy;
        t_beat b;
        int unsigned g;
        nxt_item_vld = item_ch.valid;
        nxt_cfg_vld  = cfg_ch.valid;
        nxt_rdy      = res_ch.ready;
        if (!i_rst_n) begin
            nxt_item_vld = 1'b0;
            nxt_cfg_vld  = 1'b0;
            nxt_rdy      = 1'b0;
        end else begin
            // now and then switch between paced and back-to-back running
            if ($urandom_range(0, 299) == 0)
                quiet_run = !quiet_run;
            // retire beats the monitor saw taken at the last rising edge
            if (item_ch.valid && items_taken == items_sent)
                nxt_item_vld = 1'b0;
            if (cfg_ch.valid && cfgs_taken == cfgs_sent)
                nxt_cfg_vld = 1'b0;
            if (!nxt_item_vld && !nxt_cfg_vld && pending_beats.size() != 0) begin
                if (item_gap != 0) begin
                    item_gap = item_gap - 1;
                end else if (pending_beats[0].kind == BEAT_ITEM) begin
                    b = pending_beats.pop_front();
                    item_ch.data <= b.item;
                    nxt_item_vld = 1'b1;
                    items_sent  <= items_sent + 1;
                    item_gap     = pick_gap();
                end else if (lattice_results_due.size() == 0 && items_taken == items_sent) begin
                    // registers only change with the block idle and every result home
                    b = pending_beats.pop_front();
                    cfg_ch.data <= b.cfg;
                    nxt_cfg_vld = 1'b1;
                    cfgs_sent  <= cfgs_sent + 1;
                end
            end
            // result back-pressure: low for a gap, then high for a stretch
            if (rdy_left != 0) begin
                rdy_left = rdy_left - 1;
            end else begin
                g = pick_gap();
                if (res_ch.ready && g != 0) begin
                    nxt_rdy  = 1'b0;
                    rdy_left = g - 1;
                end else begin
                    nxt_rdy  = 1'b1;
                    rdy_left = $urandom_range(0, 15);
                end
            end
        end
        item_ch.valid <= nxt_item_vld;
        cfg_ch.valid  <= nxt_cfg_vld;
        res_ch.ready  <= nxt_rdy;
    end

    // ------------------------------------------------------------------
    // monitor: samples every channel at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_blk
        logic    moved;
        t_result want;
        t_result got;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                if (cfg_ch.data.index <= REG_BACKWARD_HOP)
                    prob_reg[cfg_ch.data.index] = cfg_ch.data.value;
                cfgs_taken <= cfgs_taken + 1;
            end
            if (item_ch.valid && item_ch.ready) begin
                moved = 1'b1;
                lattice_results_due.push_back(step_lattice(item_ch.data));
                items_taken <= items_taken + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                got   = res_ch.data;
                if (lattice_results_due.size() == 0) begin
                    if (err_count < REPORT_MAX)
                        $display("result beat with nothing outstanding: occ=%0b fwd=%0d bwd=%0d cnt=%0d",
                                 got.site_occupied, got.forward_current,
                                 got.backward_current, got.occupancy_count);
                    err_count = err_count + 1;
                end else begin
                    want = lattice_results_due.pop_front();
                    if (got.site_occupied    !== want.site_occupied    ||
                        got.forward_current  !== want.forward_current  ||
                        got.backward_current !== want.backward_current ||
                        got.occupancy_count  !== want.occupancy_count) begin
                        if (err_count < REPORT_MAX)
                            $display("bad result beat: want occ=%0b fwd=%0d bwd=%0d cnt=%0d, got occ=%0b fwd=%0d bwd=%0d cnt=%0d",
                                     want.site_occupied, want.forward_current,
                                     want.backward_current, want.occupancy_count,
                                     got.site_occupied, got.forward_current,
                                     got.backward_current, got.occupancy_count);
                        err_count = err_count + 1;
                    end
                end
            end
            // watchdog on cycles where nothing moves on any channel
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("exclusion_process_lattice_step_top: mismatch");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed opening, then phases of random traffic
    // ------------------------------------------------------------------
    initial begin : stim_blk
        int   n_rand;
        int   phase;
        int   phase_end;
        int   s0;
        int   len;
        int   r;
        int   r2;
        logic meas;

        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        res_ch.ready  = 1'b0;

        for (int k = 0; k < SITES; k++) begin
            lattice_occ[k] = 1'b0;
            site_tally[k]  = '0;
        end
        fwd_tally = '0;
        bwd_tally = '0;
        for (int k = 0; k < NUM_REGS; k++)
            prob_reg[k] = PROB_MIN;

        // with reset probabilities nothing can move
        queue_item(OP_UPDATE, 8'd1, 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        queue_item(OP_READ, SITE_W'(MID_SITE), 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);

        // everything certain bar a roll at full scale; plus a dropped write
        for (int k = 0; k < NUM_REGS; k++)
            queue_cfg(REG_IDX_W'(k), PROB_MAX);
        queue_cfg(REG_UNUSED_B, PROB_MAX);

        // left boundary: inject, remove, inject then remove in one item
        queue_item(OP_UPDATE, 8'd1, 1'b1, PROB_MIN, PROB_MAX, PROB_MAX, PROB_MAX);
        queue_item(OP_UPDATE, 8'd1, 1'b1, PROB_MAX, PROB_MIN, PROB_MAX, PROB_MAX);
        queue_item(OP_UPDATE, 8'd1, 1'b1, PROB_MIN, PROB_MIN, PROB_MAX, PROB_MAX);
        // inject and hop on, hop back, then no backward hop off the first site
        queue_item(OP_UPDATE, 8'd1, 1'b1, PROB_MIN, PROB_MAX, PROB_MIN, PROB_MAX);
        queue_item(OP_UPDATE, 8'd2, 1'b1, PROB_MAX, PROB_MAX, PROB_MAX, PROB_MIN);
        queue_item(OP_UPDATE, 8'd1, 1'b1, PROB_MAX, PROB_MAX, PROB_MAX, PROB_MIN);
        // right boundary: inject, no forward hop off the last site, extract then inject
        queue_item(OP_UPDATE, SITE_W'(SITES), 1'b1, PROB_MAX, PROB_MIN, PROB_MAX, PROB_MAX);
        queue_item(OP_UPDATE, SITE_W'(SITES), 1'b1, PROB_MAX, PROB_MAX, PROB_MIN, PROB_MAX);
        queue_item(OP_UPDATE, SITE_W'(SITES), 1'b1, PROB_MIN, PROB_MIN, PROB_MAX, PROB_MAX);
        queue_item(OP_UPDATE, SITE_W'(SITES), 1'b1, PROB_MIN, PROB_MAX, PROB_MAX, PROB_MIN);
        queue_item(OP_UPDATE, SITE_W'(SITES), 1'b1, PROB_MAX, PROB_MIN, PROB_MAX, PROB_MIN);
        // out-of-range sites leave the lattice alone
        queue_item(OP_UPDATE, 8'd0, 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        queue_item(OP_UPDATE, SITE_W'(SITES + 1), 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        queue_item(OP_UPDATE, 8'd255, 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        // sweeps counting, not counting, and reporting an out-of-range site
        queue_item(OP_SWEEP, 8'd1, 1'b1, PROB_MAX, PROB_MAX, PROB_MAX, PROB_MAX);
        queue_item(OP_SWEEP, SITE_W'(SITES - 1), 1'b0, PROB_MAX, PROB_MAX, PROB_MAX, PROB_MAX);
        queue_item(OP_SWEEP, 8'd0, 1'b1, PROB_MAX, PROB_MAX, PROB_MAX, PROB_MAX);
        // reads, the spare code among them
        queue_item(OP_READ, SITE_W'(SITES - 1), 1'b0, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        queue_item(OP_SPARE, 8'd1, 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        queue_item(OP_SPARE, 8'd200, 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);
        queue_item(OP_READ, 8'd0, 1'b1, PROB_MIN, PROB_MIN, PROB_MIN, PROB_MIN);

        // random phases: passes along the lattice carry particles through the middle
        n_rand = 0;
        phase  = 0;
        while (n_rand < RAND_ITEMS) begin
            queue_phase_config(phase);
            phase_end = n_rand + $urandom_range(80, 160);
            while (n_rand < phase_end && n_rand < RAND_ITEMS) begin
                r    = $urandom_range(0, 99);
                meas = ($urandom_range(0, 99) < 85);
                if (r < 30) begin
                    // ascending pass, mostly from the left boundary
                    s0  = ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(1, SITES);
                    len = $urandom_range(4, 80);
                    for (int k = 0; k < len && s0 + k <= SITES; k++) begin
                        queue_rand_item(OP_UPDATE, SITE_W'(s0 + k), meas);
                        n_rand++;
                    end
                end else if (r < 45) begin
                    // descending pass, mostly from the right boundary
                    s0  = ($urandom_range(0, 1) != 0) ? SITES : $urandom_range(1, SITES);
                    len = $urandom_range(4, 80);
                    for (int k = 0; k < len && s0 - k >= 1; k++) begin
                        queue_rand_item(OP_UPDATE, SITE_W'(s0 - k), meas);
                        n_rand++;
                    end
                end else if (r < 55) begin
                    // churn around the middle site
                    len = $urandom_range(5, 15);
                    for (int k = 0; k < len; k++) begin
                        queue_rand_item(OP_UPDATE,
                                        SITE_W'($urandom_range(MID_SITE - 2, MID_SITE + 2)),
                                        meas);
                        n_rand++;
                    end
                end else begin
                    // single item of any kind, noise included
                    r2 = $urandom_range(0, 99);
                    if (r2 < 55)
                        queue_rand_item(OP_UPDATE, draw_site(), meas);
                    else if (r2 < 70)
                        queue_rand_item(OP_SWEEP, draw_site(), meas);
                    else if (r2 < 90)
                        queue_rand_item(OP_READ, draw_site(), meas);
                    else
                        queue_rand_item(OP_SPARE, draw_site(), meas);
                    n_rand++;
                end
            end
            phase++;
        end

        // reset held low, then released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every beat to be taken and every result to be home
        @(posedge i_clk);
        while (pending_beats.size() != 0 || items_taken != items_sent ||
               cfgs_taken != cfgs_sent || lattice_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && lattice_results_due.size() == 0) begin
            $display("exclusion_process_lattice_step_top: match");
        end else begin
            $display("exclusion_process_lattice_step_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/epls_pkg.sv
sv/epls_chan_if.sv
sv/epls_ram.sv
sv/exclusion_process_lattice_step_top.sv
sv/epls_checker.sv
tb/tb_exclusion_process_lattice_step_top.sv
